/* rtl/core/vam_pkg.sv */
// Shared types and constants for the vertex attribute morph pipeline.
// No dependencies; every module of the block imports it.
package vam_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int WEIGHT_W     = WEIGHT_BITS + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;
    localparam int NORM_BIT     = 29;
    localparam int ROOT_W       = 32;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int NUM_W        = 32 + FRAC_BITS + 1;
    localparam logic [DIV_STEPS-1:0] UNIT = DIV_STEPS'(1) << FRAC_BITS;

    localparam int BLEND_STAGES = 3;
    localparam int NORM_STAGES  = 6;
    localparam int DIV_STAGES   = DIV_STEPS + 1;
    localparam int LATENCY      = BLEND_STAGES + NORM_STAGES + ROOT_W + DIV_STAGES + 1;

    typedef enum logic [1:0] {
        KIND_POSITION = 2'd0,
        KIND_NORMAL   = 2'd1,
        KIND_TANGENT  = 2'd2,
        KIND_TEXCOORD = 2'd3
    } t_kind;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        logic       dir;
        logic       zero;
        logic [2:0] neg;
        t_vec3      v;
    } t_side;

endpackage

/* rtl/core/vertex_attribute_morph_unit.sv */
// Vertex attribute morph: blend, then unit-length normalise for normals and tangents.
// Items pass from start to o_strobe through the blend, the normaliser, the 32-stage square
// root and the 17-step divider; one item is taken every cycle, so busy stays low.
// The receiver cannot stall; the pipeline advances every cycle.
// Synchronous active-low reset clears all valid bits and the weight register.
// Depends on vam_pkg, vam_blend, vam_norm, vam_sqrt and vam_div.
module vertex_attribute_morph_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_src_x,
    input  logic [31:0] i_src_y,
    input  logic [31:0] i_src_z,
    input  logic [31:0] i_dst_x,
    input  logic [31:0] i_dst_y,
    input  logic [31:0] i_dst_z,
    output logic        o_strobe,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z
);
    import vam_pkg::*;

    logic [WEIGHT_W-1:0] r_weight;
    logic                blend_valid, norm_valid, sqrt_valid, div_valid;
    t_side               blend_side, norm_side, sqrt_side, div_side;
    t_vec3               norm_mag, sqrt_mag;
    logic [63:0]         norm_sum;
    logic [ROOT_W-1:0]   sqrt_root;
    logic [2:0][DIV_STEPS-1:0] div_quot;
    logic                r_strobe;
    logic                r_dir;
    t_vec3               r_out;
    t_vec3               n_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    vam_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_kind   (t_kind'(i_req_type)),
        .i_src    ({i_src_z, i_src_y, i_src_x}),
        .i_dst    ({i_dst_z, i_dst_y, i_dst_x}),
        .i_weight (r_weight),
        .o_valid  (blend_valid),
        .o_side   (blend_side)
    );

    vam_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (blend_valid),
        .i_side  (blend_side),
        .o_valid (norm_valid),
        .o_side  (norm_side),
        .o_mag   (norm_mag),
        .o_sum   (norm_sum)
    );

    vam_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .i_side  (norm_side),
        .i_mag   (norm_mag),
        .i_x     (norm_sum),
        .o_valid (sqrt_valid),
        .o_side  (sqrt_side),
        .o_mag   (sqrt_mag),
        .o_root  (sqrt_root)
    );

    vam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .i_side  (sqrt_side),
        .i_mag   (sqrt_mag),
        .i_len   (sqrt_root),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    always_comb begin
        logic [DIV_STEPS-1:0] q;
        logic [31:0]          qw;
        for (int i = 0; i < 3; i++) begin
            q  = (div_quot[i] > UNIT) ? UNIT : div_quot[i];
            qw = {{(32-DIV_STEPS){1'b0}}, q};
            if (!div_side.dir) begin
                n_out[i] = div_side.v[i];
            end else if (div_side.zero) begin
                n_out[i] = 32'd0;
            end else begin
                n_out[i] = div_side.neg[i] ? (32'd0 - qw) : qw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_dir <= div_side.dir;
    end

    assign o_strobe = r_strobe;
    assign o_out_x  = r_out[0];
    assign o_out_y  = r_out[1];
    assign o_out_z  = r_out[2];

`ifndef SYNTHESIS
    localparam logic signed [31:0] S_UNIT = 32'sd1 <<< FRAC_BITS;

    a_item_emerges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted item did not emerge at the fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_dir) |->
            ($signed(o_out_x) <= S_UNIT && $signed(o_out_x) >= -S_UNIT &&
             $signed(o_out_y) <= S_UNIT && $signed(o_out_y) >= -S_UNIT &&
             $signed(o_out_z) <= S_UNIT && $signed(o_out_z) >= -S_UNIT))
        else $error("normalised component exceeds unit length");
`endif

endmodule

/* rtl/core/vam_blend.sv */
// Blend stages: difference, weight multiply, rounded add back to source.
// Depends on vam_pkg.
module vam_blend (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  vam_pkg::t_kind            i_kind,
    input  vam_pkg::t_vec3            i_src,
    input  vam_pkg::t_vec3            i_dst,
    input  logic [vam_pkg::WEIGHT_W-1:0] i_weight,
    output logic                      o_valid,
    output vam_pkg::t_side            o_side
);
    import vam_pkg::*;

    logic                  r1_valid, r2_valid, r3_valid;
    logic                  r1_dir, r2_dir, r3_dir;
    logic signed [32:0]    r1_d [3];
    logic [31:0]           r1_a [3];
    logic [WEIGHT_W-1:0]   r1_w;
    logic signed [50:0]    r2_p [3];
    logic [31:0]           r2_a [3];
    t_vec3                 r3_v;
    logic signed [50:0]    n_round [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_round[i] = (r2_p[i] + 51'sd32768) >>> WEIGHT_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dir <= (i_kind == KIND_NORMAL) || (i_kind == KIND_TANGENT);
        // saturate the weight at one
        r1_w   <= (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
        r2_dir <= r1_dir;
        r3_dir <= r2_dir;
        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= $signed({i_dst[i][31], i_dst[i]}) - $signed({i_src[i][31], i_src[i]});
            r1_a[i] <= i_src[i];
            r2_p[i] <= r1_d[i] * $signed({1'b0, r1_w});
            r2_a[i] <= r1_a[i];
            r3_v[i] <= r2_a[i] + n_round[i][31:0];
        end
    end

    assign o_valid     = r3_valid;
    assign o_side.dir  = r3_dir;
    assign o_side.zero = 1'b0;
    assign o_side.neg  = 3'b000;
    assign o_side.v    = r3_v;

endmodule

/* rtl/core/vam_norm.sv */
// Normalising front end: magnitudes, maximum, staged left shift, sum of squares.
// Depends on vam_pkg.
module vam_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vam_pkg::t_side  i_side,
    output logic            o_valid,
    output vam_pkg::t_side  o_side,
    output vam_pkg::t_vec3  o_mag,
    output logic [63:0]     o_sum
);
    import vam_pkg::*;

    logic [NORM_STAGES-1:0] r_valid;
    t_side       r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    t_vec3       r1_mag, r2_mag, r3_mag, r4_mag, r5_mag, r6_mag;
    logic [31:0] r2_mx, r3_mx;
    logic [63:0] r5_sq [3];
    logic [63:0] r6_sum;
    logic [31:0] n_mx;
    logic [31:0] n3_mx;
    t_vec3       n3_mag;
    logic [31:0] n4_mx;
    t_vec3       n4_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[NORM_STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        n_mx = r1_mag[0];
        if (r1_mag[1] > n_mx) n_mx = r1_mag[1];
        if (r1_mag[2] > n_mx) n_mx = r1_mag[2];
    end

    // shift by 16 and 8 where the maximum stays below the target bit
    always_comb begin
        n3_mx  = r2_mx;
        n3_mag = r2_mag;
        if (n3_mx < (32'd1 << (NORM_BIT - 16))) begin
            n3_mx = n3_mx << 16;
            for (int i = 0; i < 3; i++) n3_mag[i] = n3_mag[i] << 16;
        end
        if (n3_mx < (32'd1 << (NORM_BIT - 8))) begin
            n3_mx = n3_mx << 8;
            for (int i = 0; i < 3; i++) n3_mag[i] = n3_mag[i] << 8;
        end
    end

    always_comb begin
        n4_mx  = r3_mx;
        n4_mag = r3_mag;
        if (n4_mx < (32'd1 << (NORM_BIT - 4))) begin
            n4_mx = n4_mx << 4;
            for (int i = 0; i < 3; i++) n4_mag[i] = n4_mag[i] << 4;
        end
        if (n4_mx < (32'd1 << (NORM_BIT - 2))) begin
            n4_mx = n4_mx << 2;
            for (int i = 0; i < 3; i++) n4_mag[i] = n4_mag[i] << 2;
        end
        if (n4_mx < (32'd1 << (NORM_BIT - 1))) begin
            for (int i = 0; i < 3; i++) n4_mag[i] = n4_mag[i] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= {i_side.dir, i_side.zero,
                    i_side.v[2][31], i_side.v[1][31], i_side.v[0][31], i_side.v};
        for (int i = 0; i < 3; i++) begin
            r1_mag[i]      <= i_side.v[i][31] ? (32'd0 - i_side.v[i]) : i_side.v[i];
        end
        r2_side      <= {r1_side.dir, (n_mx == 32'd0), r1_side.neg, r1_side.v};
        r2_mag       <= r1_mag;
        r2_mx        <= n_mx;
        r3_side      <= r2_side;
        r3_mag       <= n3_mag;
        r3_mx        <= n3_mx;
        r4_side      <= r3_side;
        r4_mag       <= n4_mag;
        r5_side      <= r4_side;
        r5_mag       <= r4_mag;
        for (int i = 0; i < 3; i++) begin
            r5_sq[i] <= 64'(r4_mag[i]) * 64'(r4_mag[i]);
        end
        r6_side <= r5_side;
        r6_mag  <= r5_mag;
        r6_sum  <= r5_sq[0] + r5_sq[1] + r5_sq[2];
    end

    assign o_valid = r_valid[NORM_STAGES-1];
    assign o_side  = r6_side;
    assign o_mag   = r6_mag;
    assign o_sum   = r6_sum;

endmodule

/* rtl/core/vam_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on vam_pkg.
module vam_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  vam_pkg::t_side          i_side,
    input  vam_pkg::t_vec3          i_mag,
    input  logic [63:0]             i_x,
    output logic                    o_valid,
    output vam_pkg::t_side          o_side,
    output vam_pkg::t_vec3          o_mag,
    output logic [vam_pkg::ROOT_W-1:0] o_root
);
    import vam_pkg::*;

    logic              s_valid [ROOT_W+1];
    t_side             s_side  [ROOT_W+1];
    t_vec3             s_mag   [ROOT_W+1];
    logic [63:0]       s_x     [ROOT_W+1];
    logic [33:0]       s_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] s_root  [ROOT_W+1];

    assign s_valid[0] = i_valid;
    assign s_side[0]  = i_side;
    assign s_mag[0]   = i_mag;
    assign s_x[0]     = i_x;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [33:0] n_sh;
        logic [33:0] n_trial;

        assign n_sh    = {s_rem[k][31:0], s_x[k][2*B+1 -: 2]};
        assign n_trial = {s_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_valid[k+1] <= 1'b0;
            end else begin
                s_valid[k+1] <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            s_side[k+1] <= s_side[k];
            s_mag[k+1]  <= s_mag[k];
            s_x[k+1]    <= s_x[k];
            if (n_sh >= n_trial) begin
                s_rem[k+1]  <= n_sh - n_trial;
                s_root[k+1] <= {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                s_rem[k+1]  <= n_sh;
                s_root[k+1] <= {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = s_valid[ROOT_W];
    assign o_side  = s_side[ROOT_W];
    assign o_mag   = s_mag[ROOT_W];
    assign o_root  = s_root[ROOT_W];

endmodule

/* rtl/core/vam_div.sv */
// Pipelined restoring divider: three lanes of rounded mag * unit / length.
// Depends on vam_pkg.
module vam_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  vam_pkg::t_side             i_side,
    input  vam_pkg::t_vec3             i_mag,
    input  logic [vam_pkg::ROOT_W-1:0] i_len,
    output logic                       o_valid,
    output vam_pkg::t_side             o_side,
    output logic [2:0][vam_pkg::DIV_STEPS-1:0] o_quot
);
    import vam_pkg::*;

    logic                  s_valid [DIV_STEPS+1];
    t_side                 s_side  [DIV_STEPS+1];
    logic [ROOT_W-1:0]     s_len   [DIV_STEPS+1];
    logic [2:0][NUM_W-1:0] s_num   [DIV_STEPS+1];
    logic [2:0][32:0]      s_rem   [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] s_quot [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid[0] <= 1'b0;
        end else begin
            s_valid[0] <= i_valid;
        end
    end

    // numerator with half the divisor added for rounding
    always_ff @(posedge i_clk) begin
        s_side[0] <= i_side;
        s_len[0]  <= i_len;
        for (int i = 0; i < 3; i++) begin
            s_num[0][i] <= (NUM_W'(i_mag[i]) << FRAC_BITS) + NUM_W'(i_len >> 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_rem[0][i]  = {1'b0, s_num[0][i][NUM_W-1 -: 32]};
            s_quot[0][i] = '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
        localparam int B = DIV_STEPS - 1 - j;
        logic [2:0][32:0] n_sh;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_sh[i] = {s_rem[j][i][31:0], s_num[j][i][B]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_valid[j+1] <= 1'b0;
            end else begin
                s_valid[j+1] <= s_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            s_side[j+1] <= s_side[j];
            s_len[j+1]  <= s_len[j];
            s_num[j+1]  <= s_num[j];
            for (int i = 0; i < 3; i++) begin
                if (n_sh[i] >= {1'b0, s_len[j]}) begin
                    s_rem[j+1][i]  <= n_sh[i] - {1'b0, s_len[j]};
                    s_quot[j+1][i] <= {s_quot[j][i][DIV_STEPS-2:0], 1'b1};
                end else begin
                    s_rem[j+1][i]  <= n_sh[i];
                    s_quot[j+1][i] <= {s_quot[j][i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = s_valid[DIV_STEPS];
    assign o_side  = s_side[DIV_STEPS];
    assign o_quot  = s_quot[DIV_STEPS];

endmodule

/* tb/testbench.sv */
// Regression for vertex_attribute_morph_unit: blend, then unit-length normalise.
// A scoreboard class predicts every item; tasks drive start in bursts.
// Depends on vam_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import vam_pkg::*;

    localparam int N_RANDOM = 1600;

    class morph_board;
        logic [16:0] weight;
        t_vec3       pending[$];
        int          errors;
        int          checked;

        function new();
            weight  = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function longint mix(longint a, longint b, longint w);
            longint prod;
            longint q;
            prod = (b - a) * w;
            q = (prod + 32768) >>> 16;
            return a + q;
        endfunction

        function longint isqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void note_item(t_kind kind, t_vec3 src, t_vec3 dst);
            longint          v[3];
            longint unsigned mag[3];
            longint unsigned mx;
            longint unsigned len;
            longint unsigned q;
            longint          w;
            t_vec3           res;
            w  = (weight > 17'd65536) ? 65536 : longint'(weight);
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                v[i]   = mix(longint'($signed(src[i])), longint'($signed(dst[i])), w);
                mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > mx) mx = mag[i];
            end
            if (kind == KIND_NORMAL || kind == KIND_TANGENT) begin
                if (mx == 0) begin
                    v = '{0, 0, 0};
                end else begin
                    while (mx < (64'd1 << 29)) begin
                        mx = mx << 1;
                        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                    end
                    len = isqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
                    for (int i = 0; i < 3; i++) begin
                        q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
                        if (q > 65536) q = 65536;
                        v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
                    end
                end
            end
            for (int i = 0; i < 3; i++) res[i] = v[i][31:0];
            pending.push_back(res);
        endfunction

        function void check_result(t_vec3 got);
            t_vec3 want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h %h %h", got[0], got[1], got[2]);
                return;
            end
            want = pending.pop_front();
            if (want != got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h %h %h, got %h %h %h",
                             want[0], want[1], want[2], got[0], got[1], got[2]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [16:0] i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [31:0] i_src_x, i_src_y, i_src_z;
    logic [31:0] i_dst_x, i_dst_y, i_dst_z;
    logic        o_strobe;
    logic [31:0] o_out_x, o_out_y, o_out_z;

    morph_board board;
    int         n_items;
    int         burst_left;

    vertex_attribute_morph_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_req_type(i_req_type),
        .i_src_x(i_src_x), .i_src_y(i_src_y), .i_src_z(i_src_z),
        .i_dst_x(i_dst_x), .i_dst_y(i_dst_y), .i_dst_z(i_dst_z),
        .o_strobe(o_strobe), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result({o_out_z, o_out_y, o_out_x});
    end

    // Hold the item until accepted; gaps come between bursts.
    task automatic send_item(t_kind kind, t_vec3 src, t_vec3 dst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start      <= 1'b1;
        i_req_type <= kind;
        {i_src_z, i_src_y, i_src_x} <= src;
        {i_dst_z, i_dst_y, i_dst_x} <= dst;
        do @(posedge i_clk); while (busy);
        board.note_item(kind, src, dst);
        n_items++;
        burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_weight(logic [16:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.weight = w;
    endtask

    function automatic logic [31:0] rand_comp(int mode);
        case (mode)
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 262144)) - 131072);
            2:       return 32'($signed($urandom_range(0, 64)) - 32);
            default: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    initial begin
        t_vec3 s;
        t_vec3 d;
        logic [16:0] weights[6];
        weights = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd1, 17'd65535};
        board      = new();
        n_items    = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_wdata = '0;
        start      = 1'b0;
        i_req_type = KIND_POSITION;
        {i_src_x, i_src_y, i_src_z, i_dst_x, i_dst_y, i_dst_z} = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every kind, zero-length, weights of one and one half.
        set_weight(17'd65536);
        for (int k = 0; k < 4; k++) begin
            send_item(t_kind'(k), '{32'h7fffffff, 32'h80000000, 32'd0},
                      '{32'h80000000, 32'h7fffffff, 32'hffffffff});
            send_item(t_kind'(k), '{32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0});
            send_item(t_kind'(k), '{32'd1, 32'hffffffff, 32'd0}, '{32'd1, 32'hffffffff, 32'd0});
        end
        drain();
        set_weight(17'd32768);
        send_item(KIND_NORMAL, '{32'd5, 32'd0, 32'd0}, '{32'hfffffffb, 32'd0, 32'd0});
        send_item(KIND_TANGENT, '{32'h80000000, 32'h80000000, 32'h80000000},
                  '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        send_item(KIND_POSITION, '{32'd3, 32'hfffffffd, 32'd1}, '{32'd0, 32'd0, 32'd0});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_weight((ph % 2 == 0) ? weights[ph] : 17'($urandom()));
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                for (int i = 0; i < 3; i++) begin
                    s[i] = rand_comp($urandom_range(0, 3));
                    d[i] = ($urandom_range(0, 7) == 0) ? s[i] : rand_comp($urandom_range(0, 3));
                end
                send_item(t_kind'($urandom_range(0, 3)), s, d);
            end
            drain();
        end

        $display("covered %0d items over several blend weights, all four kinds", n_items);
        $display("%0d results checked, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) $display("vertex_attribute_morph_unit regression: pass");
        else $display("vertex_attribute_morph_unit regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("vertex_attribute_morph_unit regression: fail");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/vam_pkg.sv
rtl/core/vam_blend.sv
rtl/core/vam_norm.sv
rtl/core/vam_sqrt.sv
rtl/core/vam_div.sv
rtl/core/vertex_attribute_morph_unit.sv
tb/testbench.sv
